// ----- rtl/fbba_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbba_pkg
// Shared constants and types for the free block bitmap allocator.
// ----------------------------------------------------------------------------
package fbba_pkg;

    localparam int BLOCK_COUNT = 1024;
    localparam int MAX_REQUEST = 64;

    // bitmap word organization
    localparam int WORD_W     = 32;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int WORD_COUNT = BLOCK_COUNT / WORD_W;
    localparam int WADDR_W    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BLK_W      = WADDR_W + BIT_W;

    // item field widths
    localparam int KIND_W  = 2;
    localparam int IDX_W   = 10;
    localparam int WANT_W  = 7;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;
    localparam int M_USER_W = 2;

    localparam logic [KIND_W-1:0] KIND_MARK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TEST = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIND = 2'd2;

    typedef struct packed {
        logic             any;
        logic [BIT_W-1:0] pos;
    } penc_t;

endpackage
`default_nettype wire

// ----- rtl/fbba_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbba_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fbba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                             aclk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  wire logic [WIDTH-1:0]                 wr_data,
    input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic      [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ----- rtl/fbba_penc.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbba_penc
// Priority encoder: position of the lowest set bit of one bitmap word.
// ----------------------------------------------------------------------------
module fbba_penc (
    input  wire logic [fbba_pkg::WORD_W-1:0] word,
    output fbba_pkg::penc_t                  res
);

    always_comb begin
        res.any = |word;
        res.pos = '0;
        for (int i = fbba_pkg::WORD_W - 1; i >= 0; i--) begin
            if (word[i]) begin
                res.pos = fbba_pkg::BIT_W'(i);
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/free_block_bitmap_allocator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// free_block_bitmap_allocator_top
// Used/free bitmap over the disk blocks with mark, test and find requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_axis_*: tuser holds the request kind (mark, test,
//   find), tdata holds the block index, mark_used and want_count. Results
//   leave on m_axis_*: tdata holds block_number and used_bit, tuser holds
//   valid_block and shortfall, tlast flags the final result of a request.
//   One item is worked on at a time; s_axis_tready is low until it is done.
//   The bitmap sits in a 32-bit wide RAM; one word is read per visit and a
//   single priority encoder picks free bits out of it one per cycle unless
//   the output register is full. Mark is a read-modify-write; test reads
//   the word and then registers its result. Find reads the bitmap words in
//   order, takes free blocks out of each until the request is met, and ends
//   with a final result. Mark, unknown-kind and zero-count find requests
//   give no result; a test always gives exactly one.
//   Results sit in an output register; while m_axis_tready is low the
//   sequencer holds before its next result and no result is lost or repeated.
//   Reset (aresetn low, synchronous) clears per-word valid bits so every
//   block reads as free at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module free_block_bitmap_allocator_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [9:0] blk_idx, [10] mark_used, [17:11] want_count
    input  wire logic [fbba_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // [1:0] kind
    input  wire logic [fbba_pkg::KIND_W-1:0]     s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [9:0] block_number, [10] used_bit
    output logic [fbba_pkg::M_DATA_W-1:0]        m_axis_tdata,
    // [0] valid_block, [1] shortfall
    output logic [fbba_pkg::M_USER_W-1:0]        m_axis_tuser,
    output logic                                 m_axis_tlast
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_TEST  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    localparam int W  = fbba_pkg::WORD_W;
    localparam int BW = fbba_pkg::BIT_W;
    localparam int AW = fbba_pkg::WADDR_W;
    localparam int NW = fbba_pkg::WANT_W;
    localparam int XW = fbba_pkg::IDX_W;

    logic [2:0]                   state_reg, state_next;
    logic [fbba_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic [XW-1:0]                idx_reg, idx_next;
    logic                         mark_reg, mark_next;
    logic                         oor_reg, oor_next;
    logic                         used_reg, used_next;
    logic [NW-1:0]                want_reg, want_next;
    logic [NW-1:0]                found_reg, found_next;
    logic [AW-1:0]                waddr_reg, waddr_next;
    logic [W-1:0]                 word_reg, word_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic [fbba_pkg::BLK_W-1:0]   pend_blk_reg, pend_blk_next;
    logic [fbba_pkg::WORD_COUNT-1:0] wvalid_reg, wvalid_next;
    logic                         rvalid_reg;

    logic                         m_valid_reg, m_valid_next;
    logic [XW-1:0]                m_blk_reg, m_blk_next;
    logic                         m_used_reg, m_used_next;
    logic                         m_vblk_reg, m_vblk_next;
    logic                         m_short_reg, m_short_next;
    logic                         m_last_reg, m_last_next;

    logic [XW-1:0]                in_idx;
    logic                         in_mark;
    logic [NW-1:0]                in_want;
    logic                         in_range;
    logic                         in_accept;
    logic                         out_free;
    logic                         wr_en;
    logic [W-1:0]                 wr_data;
    logic [W-1:0]                 rd_data;
    logic [W-1:0]                 word_in;
    logic [W-1:0]                 bit_sel;
    logic [NW-1:0]                found_inc;
    fbba_pkg::penc_t              penc;

    assign in_idx   = s_axis_tdata[XW-1:0];
    assign in_mark  = s_axis_tdata[XW];
    assign in_want  = s_axis_tdata[XW+NW:XW+1];
    assign in_range = {1'b0, in_idx} < (XW+1)'(fbba_pkg::BLOCK_COUNT);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign word_in   = rvalid_reg ? rd_data : '0;
    assign bit_sel   = W'(1) << idx_reg[BW-1:0];
    assign found_inc = found_reg + NW'(1);
    assign wr_data   = mark_reg ? (word_in | bit_sel) : (word_in & ~bit_sel);

    fbba_ram #(
        .WIDTH (W),
        .DEPTH (fbba_pkg::WORD_COUNT)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (waddr_reg),
        .wr_data (wr_data),
        .rd_addr (waddr_next),
        .rd_data (rd_data)
    );

    fbba_penc u_penc (
        .word (word_reg),
        .res  (penc)
    );

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        idx_next        = idx_reg;
        mark_next       = mark_reg;
        oor_next        = oor_reg;
        used_next       = used_reg;
        want_next       = want_reg;
        found_next      = found_reg;
        waddr_next      = waddr_reg;
        word_next       = word_reg;
        pend_valid_next = pend_valid_reg;
        pend_blk_next   = pend_blk_reg;
        wvalid_next     = wvalid_reg;
        wr_en           = 1'b0;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_blk_next      = m_blk_reg;
        m_used_next     = m_used_reg;
        m_vblk_next     = m_vblk_reg;
        m_short_next    = m_short_reg;
        m_last_next     = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    kind_next = s_axis_tuser;
                    idx_next  = in_idx;
                    mark_next = in_mark;
                    oor_next  = !in_range;
                    unique case (s_axis_tuser)
                        fbba_pkg::KIND_MARK: begin
                            if (in_range) begin
                                waddr_next = in_idx[BW +: AW];
                                state_next = ST_READ;
                            end
                        end
                        fbba_pkg::KIND_TEST: begin
                            waddr_next = in_idx[BW +: AW];
                            used_next  = 1'b0;
                            state_next = in_range ? ST_READ : ST_TEST;
                        end
                        fbba_pkg::KIND_FIND: begin
                            if (in_want != '0) begin
                                want_next       = (in_want > NW'(fbba_pkg::MAX_REQUEST))
                                                ? NW'(fbba_pkg::MAX_REQUEST) : in_want;
                                found_next      = '0;
                                pend_valid_next = 1'b0;
                                waddr_next      = '0;
                                state_next      = ST_READ;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                unique case (kind_reg)
                    fbba_pkg::KIND_MARK: begin
                        wr_en                  = 1'b1;
                        wvalid_next[waddr_reg] = 1'b1;
                        state_next             = ST_IDLE;
                    end
                    fbba_pkg::KIND_TEST: begin
                        used_next  = |(word_in & bit_sel);
                        state_next = ST_TEST;
                    end
                    default: begin
                        // block 0 is reserved and never handed out
                        word_next  = ~word_in & ~W'(waddr_reg == '0);
                        state_next = ST_SCAN;
                    end
                endcase
            end
            ST_TEST: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_blk_next   = idx_reg;
                    m_used_next  = used_reg;
                    m_vblk_next  = !oor_reg;
                    m_short_next = 1'b0;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (!penc.any) begin
                    if (waddr_reg == AW'(fbba_pkg::WORD_COUNT - 1)) begin
                        state_next = ST_FLUSH;
                    end else begin
                        waddr_next = waddr_reg + AW'(1);
                        state_next = ST_READ;
                    end
                end else if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_blk_next   = XW'(pend_blk_reg);
                        m_used_next  = 1'b0;
                        m_vblk_next  = 1'b1;
                        m_short_next = 1'b0;
                        m_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_blk_next   = {waddr_reg, penc.pos};
                    word_next       = word_reg & ~(W'(1) << penc.pos);
                    found_next      = found_inc;
                    if (found_inc == want_reg) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_used_next  = 1'b0;
                    m_last_next  = 1'b1;
                    if (pend_valid_reg) begin
                        m_blk_next   = XW'(pend_blk_reg);
                        m_vblk_next  = 1'b1;
                        m_short_next = found_reg < want_reg;
                    end else begin
                        m_blk_next   = '0;
                        m_vblk_next  = 1'b0;
                        m_short_next = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            found_reg      <= '0;
            want_reg       <= '0;
            wvalid_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            found_reg      <= found_next;
            want_reg       <= want_next;
            wvalid_reg     <= wvalid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        idx_reg      <= idx_next;
        mark_reg     <= mark_next;
        oor_reg      <= oor_next;
        used_reg     <= used_next;
        waddr_reg    <= waddr_next;
        word_reg     <= word_next;
        pend_blk_reg <= pend_blk_next;
        rvalid_reg   <= wvalid_reg[waddr_next];
        m_blk_reg    <= m_blk_next;
        m_used_reg   <= m_used_next;
        m_vblk_reg   <= m_vblk_next;
        m_short_reg  <= m_short_next;
        m_last_reg   <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(fbba_pkg::M_DATA_W - XW - 1){1'b0}}, m_used_reg, m_blk_reg};
    assign m_axis_tuser  = {m_short_reg, m_vblk_reg};
    assign m_axis_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_found_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_FLUSH) |-> found_reg <= want_reg)
        else $error("found count exceeds request");

    a_pend_tracks_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_FLUSH)
            |-> pend_valid_reg == (found_reg != '0))
        else $error("pending block out of step with found count");

    a_mid_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == 2'b01))
        else $error("non-final result must be a valid block without shortfall");

    a_mark_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> wvalid_reg[$past(waddr_reg)])
        else $error("written word not flagged valid");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |=> !$past(in_accept))
        else $error("item accepted during scan");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/free_block_bitmap_allocator_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_block_bitmap_allocator_top_tb
// Self-checking bench for the free block bitmap allocator.
// Sends mark, test and find requests with random gaps, mirrors the used/free
// map in a local predictor and compares every result field by field against
// the expected results, in order. Covers a fresh map, block zero, a sparsely
// used map, a long used run across several map words and a densely used map.
// ----------------------------------------------------------------------------
module free_block_bitmap_allocator_top_tb;
    import fbba_pkg::*;

    localparam logic [KIND_W-1:0] KIND_RSVD = 2'd3;
    localparam int LIMIT_CYCLES = 10_000_000;
    localparam int TAIL_CYCLES  = 150;
    localparam int USED_RUN     = 160;

    typedef struct packed {
        logic [IDX_W-1:0] block_number;
        logic             used_bit;
        logic             valid_block;
        logic             shortfall;
        logic             last;
    } alloc_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    wire logic             s_axis_tready;
    // [9:0] blk_idx, [10] mark_used, [17:11] want_count
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;
    // [1:0] kind
    logic [KIND_W-1:0]     s_axis_tuser = '0;
    wire logic             m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [9:0] block_number, [10] used_bit
    wire logic [M_DATA_W-1:0] m_axis_tdata;
    // [0] valid_block, [1] shortfall
    wire logic [M_USER_W-1:0] m_axis_tuser;
    wire logic             m_axis_tlast;

    bit            block_map [BLOCK_COUNT];
    alloc_result_t expected_results [$];
    int            fail_count = 0;
    int            cycle_count = 0;
    int            stall_left = 0;
    bit            idle_en = 1'b1;

    free_block_bitmap_allocator_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_en || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Mirror of the bitmap; queues the results one request produces.
    function automatic void predict_request(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
                                            logic mark, logic [WANT_W-1:0] want);
        alloc_result_t r;
        int            free_list [$];
        int            limit;
        r = '0;
        case (kind)
            KIND_MARK: begin
                if (int'(idx) < BLOCK_COUNT) begin
                    block_map[idx] = mark;
                end
            end
            KIND_TEST: begin
                r.block_number = idx;
                r.last = 1'b1;
                if (int'(idx) < BLOCK_COUNT) begin
                    r.used_bit = block_map[idx];
                    r.valid_block = 1'b1;
                end
                expected_results.push_back(r);
            end
            KIND_FIND: begin
                if (want != 0) begin
                    limit = (int'(want) > MAX_REQUEST) ? MAX_REQUEST : int'(want);
                    for (int b = 1; b < BLOCK_COUNT && free_list.size() < limit; b++) begin
                        if (!block_map[b]) begin
                            free_list.push_back(b);
                        end
                    end
                    if (free_list.size() == 0) begin
                        r.shortfall = 1'b1;
                        r.last = 1'b1;
                        expected_results.push_back(r);
                    end
                    foreach (free_list[i]) begin
                        r.block_number = free_list[i][IDX_W-1:0];
                        r.valid_block = 1'b1;
                        r.last = (i == free_list.size() - 1);
                        r.shortfall = r.last && (free_list.size() < limit);
                        expected_results.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_req(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx, logic mark,
                            logic [WANT_W-1:0] want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {{(S_DATA_W-IDX_W-1-WANT_W){1'b0}}, want, mark, idx};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predict_request(kind, idx, mark, want);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [WANT_W-1:0] rand_want(int big_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return '0;
        end else if (r < 10) begin
            return WANT_W'($urandom_range(MAX_REQUEST + 1, 127));
        end else if (r < 10 + big_pct) begin
            return WANT_W'($urandom_range(13, MAX_REQUEST));
        end
        return WANT_W'($urandom_range(1, 12));
    endfunction

    task automatic random_req(bit dense);
        int               r;
        logic [IDX_W-1:0] idx;
        r = $urandom_range(0, 99);
        if (!dense && $urandom_range(0, 9) < 7) begin
            idx = IDX_W'($urandom_range(0, 95));
        end else begin
            idx = IDX_W'($urandom_range(0, BLOCK_COUNT - 1));
        end
        if (r < 45) begin
            send_req(KIND_MARK, idx, $urandom_range(0, 99) < (dense ? 60 : 65),
                     WANT_W'($urandom));
        end else if (r < 65) begin
            send_req(KIND_TEST, idx, 1'($urandom), WANT_W'($urandom));
        end else if (r < 95) begin
            send_req(KIND_FIND, IDX_W'($urandom), 1'($urandom), rand_want(dense ? 60 : 10));
        end else begin
            send_req(KIND_RSVD, IDX_W'($urandom), 1'($urandom), WANT_W'($urandom));
        end
    endtask

    task automatic test_fresh_map();
        send_req(KIND_TEST, 10'd0, 1'b1, 7'd0);
        send_req(KIND_TEST, 10'd1023, 1'b0, 7'd127);
        send_req(KIND_FIND, 10'd0, 1'b0, 7'd1);
        send_req(KIND_FIND, 10'd1023, 1'b1, 7'd0);
        send_req(KIND_RSVD, 10'd1023, 1'b1, 7'd127);
        send_req(KIND_FIND, 10'd0, 1'b0, 7'd127);
        send_req(KIND_FIND, 10'd0, 1'b0, 7'd64);
        wait_idle();
    endtask

    task automatic test_block_zero();
        send_req(KIND_MARK, 10'd0, 1'b1, 7'd0);
        send_req(KIND_TEST, 10'd0, 1'b0, 7'd0);
        send_req(KIND_FIND, 10'd0, 1'b0, 7'd1);
        send_req(KIND_MARK, 10'd0, 1'b0, 7'd0);
        send_req(KIND_TEST, 10'd0, 1'b0, 7'd0);
        wait_idle();
    endtask

    task automatic test_mark_and_test();
        send_req(KIND_MARK, 10'd1023, 1'b1, 7'd127);
        send_req(KIND_TEST, 10'd1023, 1'b0, 7'd0);
        send_req(KIND_MARK, 10'd1, 1'b1, 7'd0);
        send_req(KIND_MARK, 10'd3, 1'b1, 7'd0);
        send_req(KIND_FIND, 10'd0, 1'b0, 7'd3);
        send_req(KIND_MARK, 10'd1023, 1'b0, 7'd0);
        send_req(KIND_TEST, 10'd1023, 1'b1, 7'd0);
        wait_idle();
    endtask

    task automatic test_random_sparse(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) begin
                idle_en = ($urandom_range(0, 3) != 0);
            end
            random_req(1'b0);
        end
        idle_en = 1'b1;
        wait_idle();
    endtask

    task automatic test_used_run();
        idle_en = 1'b0;
        for (int b = 0; b < USED_RUN; b++) begin
            send_req(KIND_MARK, IDX_W'(b), 1'b1, WANT_W'($urandom));
        end
        idle_en = 1'b1;
        send_req(KIND_FIND, 10'd0, 1'b0, 7'd5);
        send_req(KIND_TEST, 10'd100, 1'b0, 7'd0);
        send_req(KIND_MARK, 10'd70, 1'b0, 7'd0);
        send_req(KIND_MARK, IDX_W'(USED_RUN - 1), 1'b0, 7'd0);
        send_req(KIND_FIND, 10'd0, 1'b0, 7'd10);
        send_req(KIND_FIND, 10'd0, 1'b0, 7'd2);
        send_req(KIND_FIND, 10'd0, 1'b0, 7'd1);
        wait_idle();
    endtask

    task automatic test_random_dense(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                idle_en = ($urandom_range(0, 3) != 0);
            end
            random_req(1'b1);
        end
        idle_en = 1'b1;
        wait_idle();
    endtask

    // result side back-pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        alloc_result_t got;
        alloc_result_t want_r;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.block_number = m_axis_tdata[IDX_W-1:0];
            got.used_bit     = m_axis_tdata[IDX_W];
            got.valid_block  = m_axis_tuser[0];
            got.shortfall    = m_axis_tuser[1];
            got.last         = m_axis_tlast;
            if (expected_results.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result blk=%0d used=%0b valid=%0b short=%0b last=%0b",
                         $time, got.block_number, got.used_bit, got.valid_block,
                         got.shortfall, got.last);
            end else begin
                want_r = expected_results.pop_front();
                if (got !== want_r) begin
                    fail_count++;
                    $display("%0t: mismatch expected blk=%0d used=%0b valid=%0b short=%0b last=%0b",
                             $time, want_r.block_number, want_r.used_bit, want_r.valid_block,
                             want_r.shortfall, want_r.last);
                    $display("%0t:          actual   blk=%0d used=%0b valid=%0b short=%0b last=%0b",
                             $time, got.block_number, got.used_bit, got.valid_block,
                             got.shortfall, got.last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        foreach (block_map[b]) begin
            block_map[b] = 1'b0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_fresh_map();
        test_block_zero();
        test_mark_and_test();
        test_random_sparse(120);
        test_used_run();
        test_random_dense(130);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
